// ===== sv/fifo_sjf_rr_job_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the job scheduler
// Shared implication and next-cycle forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef FIFO_SJF_RR_JOB_SCHEDULER_MACROS_SVH
`define FIFO_SJF_RR_JOB_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FSJS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication, disabled while in reset
`define FSJS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// ===== sv/fsjs_pkg.sv =====
// ----------------------------------------------------------------------------
// fsjs_pkg
// Types, codes and sizes shared by the job scheduler modules.
// ----------------------------------------------------------------------------
package fsjs_pkg;

	// Table size and derived widths
	localparam int MAX_JOBS = 16;
	localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_JOBS - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_JOBS);

	// Actions
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_RUN   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Policies (code three behaves as first in first out)
	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_RR   = 2'd2;

	// Result status codes
	localparam logic [2:0] STS_LOADED   = 3'd0;
	localparam logic [2:0] STS_REJECTED = 3'd1;
	localparam logic [2:0] STS_RAN      = 3'd2;
	localparam logic [2:0] STS_NONE     = 3'd3;
	localparam logic [2:0] STS_CLEARED  = 3'd4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE  = 1'd1;

	// One stored job
	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] length;
		logic [15:0] arrival;
	} entry_t;

	// Scan beat towards the picker
	typedef struct packed {
		logic              start;
		logic              step;
		logic              vld;
		logic [SLOT_W-1:0] slot;
	} pick_ctl_t;

	// Best job found so far
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		entry_t            entry;
	} pick_res_t;

	// One result beat
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  job_id;
		logic [15:0] run_length;
		logic [31:0] start_time;
		logic [31:0] finish_time;
		logic        job_completed;
		logic [4:0]  jobs_waiting;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_SCAN,
		ST_RUN_SCAN,
		ST_RUN_DRAIN,
		ST_RUN_EXEC,
		ST_RESULT
	} state_t;

endpackage

// ===== sv/fifo_sjf_rr_job_scheduler.sv =====
// ----------------------------------------------------------------------------
// fifo_sjf_rr_job_scheduler
// Job table with first in first out, shortest job first and round robin
// selection; one result beat per input beat.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_ready     action, job_length
// out       source     out_valid / out_ready   status, job_id, run_length,
//                                              start_time, finish_time,
//                                              job_completed, jobs_waiting
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Run: the job RAM read port visits one slot per cycle.
// Load walks the valid bits to the first free slot.
// Clear, rejected loads and ignored actions go straight to the result state.
// Reset clears all valid bits at once; no clearing pass runs over the RAM.
// One result beat waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`include "fifo_sjf_rr_job_scheduler_macros.svh"

module fifo_sjf_rr_job_scheduler import fsjs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [15:0]          job_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [7:0]           job_id,
	output logic [15:0]          run_length,
	output logic [31:0]          start_time,
	output logic [31:0]          finish_time,
	output logic                 job_completed,
	output logic [4:0]           jobs_waiting,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	state_t              state_q, state_d;
	logic [1:0]          policy_q;
	logic [15:0]         slice_q;
	logic [31:0]         elapsed_q;
	logic [7:0]          next_id_q;
	logic [15:0]         next_arr_q;
	logic [CNT_W-1:0]    held_q;
	logic [MAX_JOBS-1:0] valid_q;
	logic [SLOT_W-1:0]   scan_q;
	logic [15:0]         len_q;
	res_t                res_q;
	res_t                out_q;
	logic                out_valid_q;
	logic                step_s1;
	logic                vld_s1;
	logic [SLOT_W-1:0]   slot_s1;

	logic                accept;
	logic                out_free;
	logic                rd_en;
	logic                wr_en;
	logic [SLOT_W-1:0]   wr_addr;
	entry_t              wr_data;
	entry_t              rd_data;
	pick_ctl_t           pick_ctl;
	pick_res_t           best;
	logic [15:0]         quantum;
	logic [15:0]         run_len;
	logic [15:0]         rem_left;
	logic [32:0]         sum;
	logic [31:0]         finish;
	logic                done;

	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// Work out the run of the chosen job
	always_comb begin
		quantum  = (slice_q == 16'd0) ? 16'd1 : slice_q;
		if ((policy_q == POL_RR) && (best.entry.length > quantum)) begin
			run_len = quantum;
		end else begin
			run_len = best.entry.length;
		end
		rem_left = best.entry.length - run_len;
		sum      = {1'b0, elapsed_q} + {17'd0, run_len};
		finish   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		done     = rem_left == 16'd0;
	end

	// Next state, handshake and RAM controls
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = scan_q;
		wr_data  = '{id: next_id_q, length: len_q, arrival: next_arr_q};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (action)
						ACT_LOAD:  state_d = (held_q >= FULL_CNT) ? ST_RESULT : ST_LOAD_SCAN;
						ACT_RUN:   state_d = ST_RUN_SCAN;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_LOAD_SCAN: begin
				if (!valid_q[scan_q]) begin
					wr_en   = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_RUN_SCAN: begin
				rd_en = 1'b1;
				if (scan_q == LAST_SLOT) begin
					state_d = ST_RUN_DRAIN;
				end
			end
			ST_RUN_DRAIN: begin
				state_d = ST_RUN_EXEC;
			end
			ST_RUN_EXEC: begin
				wr_addr = best.slot;
				wr_data = '{id: best.entry.id, length: rem_left, arrival: next_arr_q};
				wr_en   = best.found && !done;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIFO;
			slice_q  <= 16'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_POLICY: policy_q <= cfg_data[1:0];
				CFG_SLICE:  slice_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Scheduler state: table occupancy, time and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q  <= 32'd0;
			next_id_q  <= 8'd0;
			next_arr_q <= 16'd0;
			held_q     <= '0;
			valid_q    <= '0;
			scan_q     <= '0;
			step_s1    <= 1'b0;
		end else begin
			step_s1 <= state_q == ST_RUN_SCAN;
			case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					if (accept && (action == ACT_CLEAR)) begin
						elapsed_q  <= 32'd0;
						next_id_q  <= 8'd0;
						next_arr_q <= 16'd0;
						held_q     <= '0;
						valid_q    <= '0;
					end
				end
				ST_LOAD_SCAN: begin
					if (!valid_q[scan_q]) begin
						valid_q[scan_q] <= 1'b1;
						next_id_q       <= next_id_q + 8'd1;
						next_arr_q      <= next_arr_q + 16'd1;
						held_q          <= held_q + CNT_W'(1);
					end else begin
						scan_q <= scan_q + SLOT_W'(1);
					end
				end
				ST_RUN_SCAN: begin
					if (scan_q != LAST_SLOT) begin
						scan_q <= scan_q + SLOT_W'(1);
					end
				end
				ST_RUN_EXEC: begin
					if (best.found) begin
						elapsed_q <= finish;
						if (done) begin
							valid_q[best.slot] <= 1'b0;
							held_q             <= held_q - CNT_W'(1);
						end else begin
							next_arr_q <= next_arr_q + 16'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Scan pipeline beside the RAM read
	always_ff @(posedge clk) begin
		vld_s1  <= valid_q[scan_q];
		slot_s1 <= scan_q;
	end

	// Build the pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					len_q <= job_length;
					case (action)
						ACT_LOAD: begin
							res_q <= '{status: STS_REJECTED, job_id: next_id_q,
								run_length: job_length, start_time: 32'd0,
								finish_time: 32'd0, job_completed: 1'b0,
								jobs_waiting: 5'(held_q)};
						end
						ACT_CLEAR: begin
							res_q <= '{status: STS_CLEARED, job_id: 8'd0,
								run_length: 16'd0, start_time: 32'd0,
								finish_time: 32'd0, job_completed: 1'b0,
								jobs_waiting: 5'd0};
						end
						default: begin
							res_q <= '{status: STS_NONE, job_id: 8'd0,
								run_length: 16'd0, start_time: 32'd0,
								finish_time: 32'd0, job_completed: 1'b0,
								jobs_waiting: 5'(held_q)};
						end
					endcase
				end
			end
			ST_LOAD_SCAN: begin
				res_q <= '{status: STS_LOADED, job_id: next_id_q,
					run_length: len_q, start_time: 32'd0,
					finish_time: 32'd0, job_completed: 1'b0,
					jobs_waiting: 5'(held_q + CNT_W'(1))};
			end
			ST_RUN_EXEC: begin
				if (best.found) begin
					res_q <= '{status: STS_RAN, job_id: best.entry.id,
						run_length: run_len, start_time: elapsed_q,
						finish_time: finish, job_completed: done,
						jobs_waiting: done ? 5'(held_q - CNT_W'(1)) : 5'(held_q)};
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign job_id        = out_q.job_id;
	assign run_length    = out_q.run_length;
	assign start_time    = out_q.start_time;
	assign finish_time   = out_q.finish_time;
	assign job_completed = out_q.job_completed;
	assign jobs_waiting  = out_q.jobs_waiting;

	// Picker and table storage
	assign pick_ctl = '{start: accept, step: step_s1, vld: vld_s1, slot: slot_s1};

	fsjs_job_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_q),
		.rd_data (rd_data)
	);

	fsjs_picker u_picker (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pick_ctl),
		.rd_data  (rd_data),
		.policy   (policy_q),
		.next_arr (next_arr_q),
		.best     (best)
	);

	// Occupancy count matches the valid bits
	`FSJS_ASSERT_IMPL(a_held_matches_valid, clk, arst_n, 1'b1, $countones(valid_q) == held_q)
	// No table write while the scan is reading
	`FSJS_ASSERT_IMPL(a_no_write_in_scan, clk, arst_n, state_q == ST_RUN_SCAN, !wr_en)
	// A finished result reaches the output register
	`FSJS_ASSERT_NEXT(a_result_issued, clk, arst_n, (state_q == ST_RESULT) && out_free, out_valid_q)

endmodule

// ===== sv/fsjs_job_ram.sv =====
// ----------------------------------------------------------------------------
// fsjs_job_ram
// Job table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fsjs_job_ram import fsjs_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_addr,
	input  entry_t            wr_data,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output entry_t            rd_data
);

	entry_t mem [MAX_JOBS];

	// Write the entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, enabled by rd_en
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/fsjs_picker.sv =====
// ----------------------------------------------------------------------------
// fsjs_picker
// Keeps the best job seen during a table scan, one entry per beat.
// ----------------------------------------------------------------------------
module fsjs_picker import fsjs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pick_ctl_t   ctl,
	input  entry_t      rd_data,
	input  logic [1:0]  policy,
	input  logic [15:0] next_arr,
	output pick_res_t   best
);

	logic              found_q;
	logic [SLOT_W-1:0] slot_q;
	entry_t            entry_q;
	logic [15:0]       age_q;
	logic [15:0]       age;
	logic              better;
	logic              take;

	// Compare the incoming entry against the best so far
	always_comb begin
		age = next_arr - rd_data.arrival;
		if (policy == POL_SJF) begin
			better = (rd_data.length < entry_q.length) ||
				((rd_data.length == entry_q.length) && (age > age_q));
		end else begin
			better = age > age_q;
		end
		take = ctl.step && ctl.vld && (!found_q || better);
	end

	// Track whether anything has been found
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// Hold the winning entry
	always_ff @(posedge clk) begin
		if (take) begin
			slot_q  <= ctl.slot;
			entry_q <= rd_data;
			age_q   <= age;
		end
	end

	assign best.found = found_q;
	assign best.slot  = slot_q;
	assign best.entry = entry_q;

endmodule
